/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies; take in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked in the following cycle.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/eirp_pkg.sv */
// Shared types and constants for the escaped info record parser.
// No dependencies.
package eirp_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_UP_X   = 8'h58;

    localparam logic [15:0] ID_LIMIT_RESET = 16'hFFFF;
    localparam logic [16:0] ACC_SAT        = 17'h10000;

    typedef enum logic [1:0] {
        KIND_KEY   = 2'd0,
        KIND_VALUE = 2'd1,
        KIND_REC   = 2'd2,
        KIND_END   = 2'd3
    } kind_t;

    typedef enum logic [4:0] {
        PH_REC_START = 5'b00001,
        PH_ID_SPACE  = 5'b00010,
        PH_ID_NUM    = 5'b00100,
        PH_KEY       = 5'b01000,
        PH_VALUE     = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        RADIX_UNDECIDED = 2'd0,
        RADIX_DEC       = 2'd1,
        RADIX_OCT       = 2'd2,
        RADIX_HEX       = 2'd3
    } radix_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  ch;
        logic [15:0] id;
        logic        ok;
        logic        last;
    } result_t;

endpackage

/* sv/escaped_info_record_parser_top.sv */
// Top level of the escaped info record parser: byte parser and result queue.
// Depends on eirp_pkg.
//
// Takes one byte of a "id:key:value;" record string per cycle and gives decoded key
// and value bytes, a record-done result carrying the id, and a summary on the final
// byte. The parser state is updated in the cycle a byte is transferred, and its zero,
// one or two results go into a four-entry result queue; results leave it one per cycle
// while out_stall is low. A byte is taken in every cycle while the queue has at least
// two free entries, so the sustained rate is one byte per cycle, bounded only by
// results draining at one per cycle. id_limit may be written while the block is idle;
// it resets to 65535.
module escaped_info_record_parser_top
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wen,
    input  logic [15:0]            cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             text_byte,
    input  logic                   string_end,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             result_kind,
    output logic [7:0]             decoded_char,
    output logic [15:0]            record_id,
    output logic                   string_ok,
    output logic                   run_last
);
    import eirp_pkg::*;

    logic [15:0]  id_limit_reg;
    phase_t       phase_reg, phase_next;
    logic [16:0]  acc_reg, acc_next;
    radix_t       radix_reg, radix_next;
    logic         minus_reg, minus_next;
    logic         digits_reg, digits_next;
    logic         esc_reg, esc_next;
    logic         err_reg, err_next;

    result_t                fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wr_ptr_reg, wr_ptr_next, wr_ptr_b;
    logic [FIFO_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]     count_reg, count_next;

    logic        in_fire, out_fire;
    logic        do_id;
    logic        pres_valid;
    result_t     pres, endres, wr_a, wr_b;
    logic        wr_a_en, wr_b_en;
    logic [4:0]  dval;
    logic [20:0] acc_prod;
    logic        is_space;

    function automatic logic [4:0] digit_value(input logic [7:0] b);
        logic [4:0] v;
        if (b >= 8'h30 && b <= 8'h39)      v = 5'(b - 8'h30);
        else if (b >= 8'h61 && b <= 8'h66) v = 5'(b - 8'h61 + 8'd10);
        else if (b >= 8'h41 && b <= 8'h46) v = 5'(b - 8'h41 + 8'd10);
        else                               v = 5'd16;
        return v;
    endfunction

    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;
    assign in_stall = count_reg > FIFO_CW'(FIFO_DEPTH - 2);

    assign dval     = digit_value(text_byte);
    assign is_space = (text_byte == CH_SPACE) || (text_byte >= 8'd9 && text_byte <= 8'd13);

    // acc * base + digit, by shifts and adds
    always_comb
    begin
        case (radix_reg)
            RADIX_DEC: acc_prod = {1'b0, acc_reg, 3'b0} + {3'b0, acc_reg, 1'b0}
                                  + 21'(dval);
            RADIX_OCT: acc_prod = {1'b0, acc_reg, 3'b0} + 21'(dval);
            default:   acc_prod = {acc_reg, 4'b0} + 21'(dval);
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        radix_next  = radix_reg;
        minus_next  = minus_reg;
        digits_next = digits_reg;
        esc_next    = esc_reg;
        err_next    = err_reg;
        do_id       = 1'b0;
        pres_valid  = 1'b0;
        pres        = '{kind: KIND_KEY, ch: 8'd0, id: 16'd0, ok: 1'b0, last: 1'b0};

        if (!err_reg) begin
            if (text_byte == 8'd0) begin
                err_next = 1'b1;
            end else begin
                case (phase_reg)
                    PH_REC_START, PH_ID_SPACE:
                    begin
                        if (is_space) begin
                            phase_next = PH_ID_SPACE;
                        end else if (text_byte == CH_PLUS || text_byte == CH_MINUS) begin
                            minus_next = (text_byte == CH_MINUS);
                            phase_next = PH_ID_NUM;
                        end else begin
                            phase_next = PH_ID_NUM;
                            do_id      = 1'b1;
                        end
                    end
                    PH_ID_NUM:
                    begin
                        do_id = 1'b1;
                    end
                    PH_KEY, PH_VALUE:
                    begin
                        pres.kind = (phase_reg == PH_KEY) ? KIND_KEY : KIND_VALUE;
                        pres.ch   = text_byte;
                        if (esc_reg) begin
                            esc_next   = 1'b0;
                            pres_valid = 1'b1;
                        end else if (text_byte == CH_BSLASH) begin
                            esc_next = 1'b1;
                        end else if (phase_reg == PH_KEY && text_byte == CH_COLON) begin
                            phase_next = PH_VALUE;
                        end else if (phase_reg == PH_VALUE && text_byte == CH_SEMI) begin
                            pres_valid  = 1'b1;
                            pres.kind   = KIND_REC;
                            pres.ch     = 8'd0;
                            pres.id     = acc_reg[15:0];
                            phase_next  = PH_REC_START;
                            acc_next    = '0;
                            radix_next  = RADIX_UNDECIDED;
                            minus_next  = 1'b0;
                            digits_next = 1'b0;
                            esc_next    = 1'b0;
                        end else begin
                            pres_valid = 1'b1;
                        end
                    end
                    default:
                    begin
                        err_next = 1'b1;
                    end
                endcase

                if (do_id) begin
                    if (text_byte == CH_COLON) begin
                        if (!digits_reg || (minus_reg && acc_reg != '0) ||
                            acc_reg >= {1'b0, id_limit_reg}) begin
                            err_next = 1'b1;
                        end else begin
                            phase_next = PH_KEY;
                            esc_next   = 1'b0;
                        end
                    end else begin
                        case (radix_reg)
                            RADIX_UNDECIDED:
                            begin
                                if (!digits_reg) begin
                                    if (text_byte == CH_ZERO) begin
                                        digits_next = 1'b1;
                                    end else if (text_byte >= CH_ONE &&
                                                 text_byte <= CH_NINE) begin
                                        radix_next  = RADIX_DEC;
                                        acc_next    = 17'(dval);
                                        digits_next = 1'b1;
                                    end else begin
                                        err_next = 1'b1;
                                    end
                                end else if (text_byte == CH_LOW_X || text_byte == CH_UP_X) begin
                                    radix_next  = RADIX_HEX;
                                    digits_next = 1'b0;
                                end else if (dval < 5'd8) begin
                                    radix_next = RADIX_OCT;
                                    acc_next   = 17'(dval);
                                end else begin
                                    err_next = 1'b1;
                                end
                            end
                            default:
                            begin
                                if ((radix_reg == RADIX_DEC && dval < 5'd10) ||
                                    (radix_reg == RADIX_OCT && dval < 5'd8) ||
                                    (radix_reg == RADIX_HEX && dval < 5'd16)) begin
                                    acc_next = (acc_prod > 21'(ACC_SAT)) ? ACC_SAT
                                                                         : acc_prod[16:0];
                                    if (radix_reg == RADIX_HEX) begin
                                        digits_next = 1'b1;
                                    end
                                end else begin
                                    err_next = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
        end

        endres = '{kind: KIND_END, ch: 8'd0, id: 16'd0,
                   ok: !err_next && phase_next == PH_REC_START, last: 1'b1};

        if (string_end) begin
            phase_next  = PH_REC_START;
            acc_next    = '0;
            radix_next  = RADIX_UNDECIDED;
            minus_next  = 1'b0;
            digits_next = 1'b0;
            esc_next    = 1'b0;
            err_next    = 1'b0;
        end

        // process result first, summary after; last flag on whichever ends the run
        wr_a    = pres_valid ? pres : endres;
        wr_a.last = pres_valid ? !string_end : 1'b1;
        wr_b    = endres;
        wr_a_en = in_fire && (pres_valid || string_end);
        wr_b_en = in_fire && pres_valid && string_end;
    end

    assign wr_ptr_b    = wr_ptr_reg + FIFO_AW'(1);
    assign wr_ptr_next = wr_ptr_reg + FIFO_AW'(wr_a_en) + FIFO_AW'(wr_b_en);
    assign rd_ptr_next = rd_ptr_reg + FIFO_AW'(out_fire);
    assign count_next  = count_reg + FIFO_CW'(wr_a_en) + FIFO_CW'(wr_b_en)
                         - FIFO_CW'(out_fire);

    assign out_valid    = count_reg != '0;
    assign result_kind  = fifo_reg[rd_ptr_reg].kind;
    assign decoded_char = fifo_reg[rd_ptr_reg].ch;
    assign record_id    = fifo_reg[rd_ptr_reg].id;
    assign string_ok    = fifo_reg[rd_ptr_reg].ok;
    assign run_last     = fifo_reg[rd_ptr_reg].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            id_limit_reg <= ID_LIMIT_RESET;
            phase_reg    <= PH_REC_START;
            acc_reg      <= '0;
            radix_reg    <= RADIX_UNDECIDED;
            minus_reg    <= 1'b0;
            digits_reg   <= 1'b0;
            esc_reg      <= 1'b0;
            err_reg      <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end else begin
            if (cfg_wen) begin
                id_limit_reg <= cfg_wdata;
            end
            if (in_fire) begin
                phase_reg  <= phase_next;
                acc_reg    <= acc_next;
                radix_reg  <= radix_next;
                minus_reg  <= minus_next;
                digits_reg <= digits_next;
                esc_reg    <= esc_next;
                err_reg    <= err_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_a_en) begin
            fifo_reg[wr_ptr_reg] <= wr_a;
        end
        if (wr_b_en) begin
            fifo_reg[wr_ptr_b] <= wr_b;
        end
    end

endmodule

/* sv/eirp_checker.sv */
// Port-level checks for the escaped info record parser, bound to the top level.
// Depends on eirp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module eirp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  result_kind,
    input logic [7:0]  decoded_char,
    input logic [15:0] record_id,
    input logic        string_ok,
    input logic        run_last
);
    import eirp_pkg::*;

    // the summary always closes the run of results for its byte
    `ASSERT_SAME(a_end_is_last, out_valid && result_kind == KIND_END, run_last)

    `ASSERT_SAME(a_id_only_on_rec, out_valid && result_kind != KIND_REC, record_id == 16'd0)

    `ASSERT_SAME(a_ok_only_on_end, out_valid && result_kind != KIND_END, !string_ok)

    `ASSERT_SAME(a_char_only_on_field,
                 out_valid && (result_kind == KIND_REC || result_kind == KIND_END),
                 decoded_char == 8'd0)

    `ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                 out_valid && $stable(result_kind) && $stable(record_id) && $stable(run_last))

endmodule

bind escaped_info_record_parser_top eirp_checker u_eirp_checker (.*);
